// ===== rtl/core/hbs_pkg.sv =====
// shared types, constants and helpers of the heightmap bilinear sampler
package hbs_pkg;

    // default geometry and fixed point format
    localparam int MAX_COLS_DEF  = 256;
    localparam int MAX_ROWS_DEF  = 256;
    localparam int FRAC_BITS_DEF = 8;

    // fixed field widths
    localparam int CFG_W    = 9;
    localparam int IDX_W    = 8;
    localparam int TEXEL_W  = 8;
    localparam int COORD_W  = 17;
    localparam int HEIGHT_W = 24;
    localparam int OUT_FRAC = 16;

    // queue depths
    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

    // number of texel banks: row parity x column parity
    localparam int NUM_BANKS = 4;

    // configuration register indexes
    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    // input function codes
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_cmd_kind;

    // control part of one queued command
    typedef struct packed {
        t_cmd_kind  kind;
        logic [1:0] bank;      // bank of a texel write: {row[0], col[0]}
        logic       row_odd;   // parity of the base row
        logic       same_row;  // second row clamped onto the base row
        logic       col_odd;   // parity of the base column
        logic       same_col;  // second column clamped onto the base column
    } t_cmd_ctl;

    // address width of one bank
    function automatic int bank_aw(input int rows, input int cols);
        int depth;
        depth = ((rows + 1) >> 1) * ((cols + 1) >> 1);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// ===== rtl/core/hbs_ram.sv =====
// generic single write port ram with registered read
module hbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/hbs_fifo.sv =====
// small synchronous fifo built from registers
module hbs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             push_ok, pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/core/hbs_front.sv =====
// front end: map size registers, coordinate split and bank address generation
module hbs_front #(
    parameter int MAX_COLS  = hbs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS  = hbs_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = hbs_pkg::FRAC_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_cfg_we,
    input  logic                                         i_cfg_index,
    input  logic [hbs_pkg::CFG_W-1:0]                    i_cfg_data,
    input  logic                                         i_valid,
    input  logic                                         i_full,
    input  logic                                         i_func,
    input  logic [hbs_pkg::IDX_W-1:0]                    i_row_index,
    input  logic [hbs_pkg::IDX_W-1:0]                    i_col_index,
    input  logic [hbs_pkg::TEXEL_W-1:0]                  i_texel_value,
    input  logic [hbs_pkg::COORD_W-1:0]                  i_u_coord,
    input  logic [hbs_pkg::COORD_W-1:0]                  i_v_coord,
    output logic                                         o_push,
    output hbs_pkg::t_cmd_ctl                            o_ctl,
    output logic [hbs_pkg::NUM_BANKS-1:0]
                 [hbs_pkg::bank_aw(MAX_ROWS, MAX_COLS)-1:0] o_addr,
    output logic [hbs_pkg::TEXEL_W-1:0]                  o_wdata,
    output logic [FRAC_BITS:0]                           o_frac_v,
    output logic [FRAC_BITS:0]                           o_frac_u
);

    import hbs_pkg::*;

    localparam int CIW   = $clog2(MAX_COLS);
    localparam int RIW   = $clog2(MAX_ROWS);
    localparam int CSW   = $clog2(MAX_COLS + 1);
    localparam int RSW   = $clog2(MAX_ROWS + 1);
    localparam int IPW   = COORD_W - FRAC_BITS;
    localparam int FW    = FRAC_BITS + 1;
    localparam int CH    = (MAX_COLS + 1) / 2;
    localparam int AW    = bank_aw(MAX_ROWS, MAX_COLS);
    localparam int ONE   = 1 << FRAC_BITS;
    localparam int W_RST = (MAX_COLS < 256) ? MAX_COLS : 256;
    localparam int H_RST = (MAX_ROWS < 256) ? MAX_ROWS : 256;

    logic [CSW-1:0] r_width, n_width;
    logic [RSW-1:0] r_height, n_height;

    // size registers hold the already limited value
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MAP_WIDTH: begin
                    if (i_cfg_data == '0) begin
                        n_width = CSW'(1);
                    end else if (32'(i_cfg_data) > 32'(MAX_COLS)) begin
                        n_width = CSW'(MAX_COLS);
                    end else begin
                        n_width = CSW'(i_cfg_data);
                    end
                end
                REG_MAP_HEIGHT: begin
                    if (i_cfg_data == '0) begin
                        n_height = RSW'(1);
                    end else if (32'(i_cfg_data) > 32'(MAX_ROWS)) begin
                        n_height = RSW'(MAX_ROWS);
                    end else begin
                        n_height = RSW'(i_cfg_data);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CSW'(W_RST);
            r_height <= RSW'(H_RST);
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    logic [IPW-1:0] v_ip, u_ip;
    logic [RIW-1:0] v_k, v_k1, v_rp;
    logic [CIW-1:0] u_k, u_k1, u_cp;
    logic [AW-1:0]  wr_addr;
    logic           wr_in_range;
    logic           is_sample;

    always_comb begin
        is_sample = (i_func == FUNC_SAMPLE);

        // row: clamp integer part, fraction against clamped index saturates at one
        v_ip = i_v_coord[COORD_W-1:FRAC_BITS];
        v_k  = (32'(v_ip) >= 32'(r_height)) ? RIW'(r_height - 1'b1) : RIW'(v_ip);
        v_k1 = (32'(v_k) + 32'd1 >= 32'(r_height)) ? v_k : RIW'(32'(v_k) + 32'd1);
        o_frac_v = (32'(v_ip) == 32'(v_k)) ? {1'b0, i_v_coord[FRAC_BITS-1:0]} : FW'(ONE);

        // column
        u_ip = i_u_coord[COORD_W-1:FRAC_BITS];
        u_k  = (32'(u_ip) >= 32'(r_width)) ? CIW'(r_width - 1'b1) : CIW'(u_ip);
        u_k1 = (32'(u_k) + 32'd1 >= 32'(r_width)) ? u_k : CIW'(32'(u_k) + 32'd1);
        o_frac_u = (32'(u_ip) == 32'(u_k)) ? {1'b0, i_u_coord[FRAC_BITS-1:0]} : FW'(ONE);

        wr_in_range = (32'(i_row_index) < 32'(MAX_ROWS)) &&
                      (32'(i_col_index) < 32'(MAX_COLS));
        wr_addr = AW'(32'(i_row_index >> 1) * 32'(CH) + 32'(i_col_index >> 1));

        // each bank serves whichever of the two rows and columns has its parity
        for (int b = 0; b < NUM_BANKS; b++) begin
            v_rp = (v_k[0] == b[1]) ? v_k : v_k1;
            u_cp = (u_k[0] == b[0]) ? u_k : u_k1;
            o_addr[b] = is_sample ? AW'(32'(v_rp >> 1) * 32'(CH) + 32'(u_cp >> 1))
                                  : wr_addr;
        end

        o_ctl.kind     = is_sample ? CMD_SAMPLE : CMD_WRITE;
        o_ctl.bank     = {i_row_index[0], i_col_index[0]};
        o_ctl.row_odd  = v_k[0];
        o_ctl.same_row = (v_k1 == v_k);
        o_ctl.col_odd  = u_k[0];
        o_ctl.same_col = (u_k1 == u_k);
        o_wdata        = i_texel_value;

        // writes outside MAX_ROWS by MAX_COLS are taken and dropped
        o_push = i_valid && !i_full && (is_sample || wr_in_range);
    end

endmodule

// ===== rtl/core/hbs_back.sv =====
// back end: banked texel store, two blend stages and result fifo
module hbs_back #(
    parameter int MAX_COLS  = hbs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS  = hbs_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = hbs_pkg::FRAC_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_cmd_valid,
    input  hbs_pkg::t_cmd_ctl                            i_ctl,
    input  logic [hbs_pkg::NUM_BANKS-1:0]
                 [hbs_pkg::bank_aw(MAX_ROWS, MAX_COLS)-1:0] i_addr,
    input  logic [hbs_pkg::TEXEL_W-1:0]                  i_wdata,
    input  logic [FRAC_BITS:0]                           i_frac_v,
    input  logic [FRAC_BITS:0]                           i_frac_u,
    output logic                                         o_cmd_pop,
    output logic                                         o_valid,
    output logic [hbs_pkg::HEIGHT_W-1:0]                 o_height_value,
    input  logic                                         i_stall
);

    import hbs_pkg::*;

    localparam int AW    = bank_aw(MAX_ROWS, MAX_COLS);
    localparam int BDEP  = ((MAX_ROWS + 1) / 2) * ((MAX_COLS + 1) / 2);
    localparam int FW    = FRAC_BITS + 1;
    localparam int ONE   = 1 << FRAC_BITS;
    localparam int CW    = TEXEL_W + FRAC_BITS;
    localparam int BW    = TEXEL_W + 2 * FRAC_BITS;
    localparam int LSH   = (2 * FRAC_BITS <= OUT_FRAC) ? OUT_FRAC - 2 * FRAC_BITS : 0;
    localparam int RSH   = (2 * FRAC_BITS > OUT_FRAC) ? 2 * FRAC_BITS - OUT_FRAC : 1;
    localparam int UW    = $clog2(OUT_DEPTH + 1);

    // result credits: samples in flight plus results waiting in the fifo
    logic [UW-1:0] r_used, n_used;
    logic          pop_sample, pop_write, out_take;

    assign pop_write  = i_cmd_valid && (i_ctl.kind == CMD_WRITE);
    assign pop_sample = i_cmd_valid && (i_ctl.kind == CMD_SAMPLE) &&
                        (r_used < UW'(OUT_DEPTH));
    assign o_cmd_pop  = pop_write || pop_sample;
    assign out_take   = o_valid && !i_stall;

    always_comb begin
        n_used = r_used;
        if (pop_sample && !out_take) begin
            n_used = r_used + 1'b1;
        end else if (out_take && !pop_sample) begin
            n_used = r_used - 1'b1;
        end
    end

    // texel banks, indexed {row parity, column parity}
    logic [TEXEL_W-1:0] rd_data [NUM_BANKS];

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        hbs_ram #(
            .WIDTH (TEXEL_W),
            .DEPTH (BDEP)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (pop_write && (i_ctl.bank == 2'(b))),
            .i_waddr (i_addr[0]),
            .i_wdata (i_wdata),
            .i_raddr (i_addr[b]),
            .o_rdata (rd_data[b])
        );
    end

    // stage 1: aligned with bank read data
    logic          r_p1_v;
    t_cmd_ctl      r_p1_ctl;
    logic [FW-1:0] r_p1_fv, r_p1_fu;

    // stage 2: column blends
    logic          r_p2_v;
    logic [CW-1:0] r_p2_c0, r_p2_c1;
    logic [FW-1:0] r_p2_fu;

    // stage 3: finished result
    logic                r_p3_v;
    logic [HEIGHT_W-1:0] r_p3_res;

    logic [1:0]          s00, s10, s01, s11;
    logic [TEXEL_W-1:0]  t00, t10, t01, t11;
    logic [CW-1:0]       n_c0, n_c1;
    logic [BW-1:0]       blend;
    logic [HEIGHT_W-1:0] n_res;

    always_comb begin
        s00 = {r_p1_ctl.row_odd, r_p1_ctl.col_odd};
        s10 = {r_p1_ctl.same_row ? r_p1_ctl.row_odd : !r_p1_ctl.row_odd, r_p1_ctl.col_odd};
        s01 = {r_p1_ctl.row_odd, r_p1_ctl.same_col ? r_p1_ctl.col_odd : !r_p1_ctl.col_odd};
        s11 = {s10[1], s01[0]};
        t00 = rd_data[s00];
        t10 = rd_data[s10];
        t01 = rd_data[s01];
        t11 = rd_data[s11];
        n_c0 = CW'(32'(t00) * (32'(ONE) - 32'(r_p1_fv)) + 32'(t10) * 32'(r_p1_fv));
        n_c1 = CW'(32'(t01) * (32'(ONE) - 32'(r_p1_fv)) + 32'(t11) * 32'(r_p1_fv));
    end

    always_comb begin
        blend = BW'(32'(r_p2_c0) * (32'(ONE) - 32'(r_p2_fu)) + 32'(r_p2_c1) * 32'(r_p2_fu));
        if (2 * FRAC_BITS <= OUT_FRAC) begin
            n_res = HEIGHT_W'(64'(blend) << LSH);
        end else begin
            // round half up when dropping extra fraction bits
            n_res = HEIGHT_W'((64'(blend) + (64'd1 << (RSH - 1))) >> RSH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
        end else begin
            r_used <= n_used;
            r_p1_v <= pop_sample;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_ctl <= i_ctl;
        r_p1_fv  <= i_frac_v;
        r_p1_fu  <= i_frac_u;
        r_p2_c0  <= n_c0;
        r_p2_c1  <= n_c1;
        r_p2_fu  <= r_p1_fu;
        r_p3_res <= n_res;
    end

    logic ofifo_empty;

    // credits keep this fifo from overflowing
    hbs_fifo #(
        .WIDTH (HEIGHT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_p3_v),
        .i_data  (r_p3_res),
        .o_full  (),
        .i_pop   (out_take),
        .o_data  (o_height_value),
        .o_empty (ofifo_empty)
    );

    assign o_valid = !ofifo_empty;

endmodule

// ===== rtl/core/heightmap_bilinear_sampler_top.sv =====
// Heightmap bilinear sampler with clamp-to-edge addressing. Write beats (func 0) store one
// texel; sample beats (func 1) return one height with 16 fraction bits, four texels blended
// by the u and v fractions. The block takes one beat per cycle while o_stall is low, writes
// and samples mixed freely; a sample's result passes through the command queue, the bank
// read, the two blend stages and the result fifo, and waits while the command queue or the
// result fifo holds earlier beats. The rate is set by the texel store, split into four banks
// by row and column parity so that the four neighbours of a sample come out of four bank
// reads in the same cycle. A four-entry command queue parts the address front end from the
// memory and blend back end, and an eight-entry result fifo absorbs output stalls. Texels
// read before being written return undefined values. map_width and map_height may change
// only while the block is idle.
module heightmap_bilinear_sampler_top #(
    parameter int MAX_COLS  = hbs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS  = hbs_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = hbs_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [hbs_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_func,
    input  logic [hbs_pkg::IDX_W-1:0]     i_row_index,
    input  logic [hbs_pkg::IDX_W-1:0]     i_col_index,
    input  logic [hbs_pkg::TEXEL_W-1:0]   i_texel_value,
    input  logic [hbs_pkg::COORD_W-1:0]   i_u_coord,
    input  logic [hbs_pkg::COORD_W-1:0]   i_v_coord,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [hbs_pkg::HEIGHT_W-1:0]  o_height_value
);

    import hbs_pkg::*;

    localparam int AW  = bank_aw(MAX_ROWS, MAX_COLS);
    localparam int FW  = FRAC_BITS + 1;
    localparam int QW  = $bits(t_cmd_ctl) + NUM_BANKS * AW + TEXEL_W + 2 * FW;

    logic                             f_push;
    t_cmd_ctl                         f_ctl;
    logic [NUM_BANKS-1:0][AW-1:0]     f_addr;
    logic [TEXEL_W-1:0]               f_wdata;
    logic [FW-1:0]                    f_frac_v, f_frac_u;

    logic                             q_full, q_empty, q_pop;
    logic [QW-1:0]                    q_din, q_dout;

    t_cmd_ctl                         b_ctl;
    logic [NUM_BANKS-1:0][AW-1:0]     b_addr;
    logic [TEXEL_W-1:0]               b_wdata;
    logic [FW-1:0]                    b_frac_v, b_frac_u;

    assign o_stall = q_full;

    hbs_front #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .i_full        (q_full),
        .i_func        (i_func),
        .i_row_index   (i_row_index),
        .i_col_index   (i_col_index),
        .i_texel_value (i_texel_value),
        .i_u_coord     (i_u_coord),
        .i_v_coord     (i_v_coord),
        .o_push        (f_push),
        .o_ctl         (f_ctl),
        .o_addr        (f_addr),
        .o_wdata       (f_wdata),
        .o_frac_v      (f_frac_v),
        .o_frac_u      (f_frac_u)
    );

    assign q_din = {f_ctl, f_addr, f_wdata, f_frac_v, f_frac_u};

    hbs_fifo #(
        .WIDTH (QW),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (q_din),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_dout),
        .o_empty (q_empty)
    );

    assign {b_ctl, b_addr, b_wdata, b_frac_v, b_frac_u} = q_dout;

    hbs_back #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (!q_empty),
        .i_ctl          (b_ctl),
        .i_addr         (b_addr),
        .i_wdata        (b_wdata),
        .i_frac_v       (b_frac_v),
        .i_frac_u       (b_frac_u),
        .o_cmd_pop      (q_pop),
        .o_valid        (o_valid),
        .o_height_value (o_height_value),
        .i_stall        (i_stall)
    );

endmodule
